@@ src/crd_pkg.sv @@
// ============================================================================
// crd_pkg: shared constants and types for the camera ray direction unit
// Widths, register indexes and defaults, sine coefficients and the angle queue entry.
// ============================================================================
package crd_pkg;

    // coordinate and angle widths
    localparam int COORD_BITS = 12;
    localparam int ANGLE_BITS = 16;

    // configuration port
    localparam int REG_W     = 16;
    localparam int DIV_W     = 13;
    localparam int FOV_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CAM_YAW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_PITCH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOV_HORIZ    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOV_VERT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

    localparam logic [REG_W-1:0] RST_CAM_YAW      = 16'd0;
    localparam logic [REG_W-1:0] RST_CAM_PITCH    = 16'd0;
    localparam logic [FOV_W-1:0] RST_FOV_HORIZ    = 16'd10923;
    localparam logic [FOV_W-1:0] RST_FOV_VERT     = 16'd10923;
    localparam logic [DIV_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [DIV_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

    // angle offset divider: (2c + W) * F + W over 2W
    localparam int SUM_W = ((COORD_BITS + 1 > DIV_W) ? COORD_BITS + 1 : DIV_W) + 1;
    localparam int NUM_W = SUM_W + FOV_W + 1;
    localparam int REM_W = DIV_W + 1;

    // sine evaluation, Q30
    localparam int PHASE_W = 32;
    localparam int Q_W     = 31;
    localparam int SIN_LAT = 7;
    localparam logic [Q_W-1:0] ONE_Q30 = 31'd1073741824;
    localparam logic [Q_W-1:0] SIN_C1  = 31'd1686629713;
    localparam logic [Q_W-1:0] SIN_C3  = 31'd693598668;
    localparam logic [Q_W-1:0] SIN_C5  = 31'd85569306;
    localparam logic [Q_W-1:0] SIN_C7  = 31'd5026994;
    localparam logic [Q_W-1:0] SIN_C9  = 31'd172272;

    // result format
    localparam int DIR_W = 16;
    localparam logic [DIR_W-1:0] DIR_ONE = 16'd16384;

    // angle queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [ANGLE_BITS-1:0] yaw;
        logic [ANGLE_BITS-1:0] pitch;
    } t_angles;

endpackage

@@ src/crd_front.sv @@
// ============================================================================
// crd_front: view angle for one axis
// Scales the coordinate ratio by the field of view through a bit-per-stage
// divider pipeline and adds the camera base angle.
// ============================================================================
module crd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [crd_pkg::COORD_BITS-1:0] i_coord,
    input  logic [crd_pkg::REG_W-1:0]      i_base,
    input  logic [crd_pkg::FOV_W-1:0]      i_fov,
    input  logic [crd_pkg::DIV_W-1:0]      i_div,
    output logic                           o_valid,
    output logic [crd_pkg::ANGLE_BITS-1:0] o_angle
);
    import crd_pkg::*;

    logic [DIV_W-1:0]       w_w1;
    logic [REM_W-1:0]       w_den;
    logic [SUM_W-1:0]       w_sum;
    logic [SUM_W+FOV_W-1:0] w_prod;

    logic [NUM_W+1:0]       r_vld;
    logic [NUM_W-1:0]       r_dvd [NUM_W];
    logic [REM_W-1:0]       r_rem [NUM_W];
    logic [ANGLE_BITS-1:0]  r_quo [NUM_W+1];
    logic [ANGLE_BITS-1:0]  r_angle;

    logic [REM_W:0]         w_sh   [NUM_W];
    logic                   w_ge   [NUM_W];
    logic [REM_W-1:0]       w_nrem [NUM_W];

    // a zero divisor counts as one
    assign w_w1   = (i_div == '0) ? DIV_W'(1) : i_div;
    assign w_den  = {w_w1, 1'b0};
    assign w_sum  = SUM_W'({i_coord, 1'b0}) + SUM_W'(w_w1);
    assign w_prod = w_sum * i_fov;

    always_comb begin
        for (int j = 0; j < NUM_W; j++) begin
            w_sh[j]   = {r_rem[j], r_dvd[j][NUM_W-1]};
            w_ge[j]   = (w_sh[j] >= {1'b0, w_den});
            w_nrem[j] = w_ge[j] ? REM_W'(w_sh[j] - {1'b0, w_den}) : REM_W'(w_sh[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NUM_W:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd[0] <= NUM_W'(w_prod) + NUM_W'(w_w1);
        r_rem[0] <= '0;
        r_quo[0] <= '0;
        for (int j = 0; j < NUM_W - 1; j++) begin
            r_dvd[j+1] <= r_dvd[j] << 1;
            r_rem[j+1] <= w_nrem[j];
        end
        for (int j = 0; j < NUM_W; j++) begin
            r_quo[j+1] <= {r_quo[j][ANGLE_BITS-2:0], w_ge[j]};
        end
        // the quotient carries half a field of view; taking off a whole one centres the angle
        r_angle <= r_quo[NUM_W] + ANGLE_BITS'(i_base) - ANGLE_BITS'(i_fov);
    end

    assign o_valid = r_vld[NUM_W+1];
    assign o_angle = r_angle;

endmodule

@@ src/crd_fifo.sv @@
// ============================================================================
// crd_fifo: angle queue
// Short register queue between the angle front and the trig back end.
// ============================================================================
module crd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  crd_pkg::t_angles  i_data,
    input  logic              i_pop,
    output crd_pkg::t_angles  o_data,
    output logic              o_empty,
    output logic              o_full
);
    import crd_pkg::*;

    t_angles            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ src/crd_sine.sv @@
// ============================================================================
// crd_sine: pipelined Q30 sine
// Quarter-wave odd polynomial in Horner form, one multiply per stage after the phase fold.
// ============================================================================
module crd_sine (
    input  logic                               i_clk,
    input  logic [crd_pkg::PHASE_W-1:0]        i_phase,
    output logic signed [crd_pkg::PHASE_W-1:0] o_sin
);
    import crd_pkg::*;

    logic [Q_W-1:0]     r_t    [6];
    logic [1:0]         r_quad [6];
    logic [Q_W-1:0]     r_u    [4];
    logic [Q_W-1:0]     r_s    [4];
    logic signed [PHASE_W-1:0] r_sin;

    logic [Q_W-1:0]     w_t;
    logic [2*Q_W-1:0]   w_tt;
    logic [2*Q_W-1:0]   w_p2;
    logic [2*Q_W-1:0]   w_p3;
    logic [2*Q_W-1:0]   w_p4;
    logic [2*Q_W-1:0]   w_p5;
    logic [2*Q_W-1:0]   w_p6;
    logic [Q_W-1:0]     w_mag;

    // odd quarters run the wave backwards
    always_comb begin
        w_t = Q_W'(i_phase[29:0]);
        if (i_phase[30]) begin
            w_t = ONE_Q30 - w_t;
        end
    end

    assign w_tt = r_t[0] * r_t[0];
    assign w_p2 = r_u[0] * SIN_C9;
    assign w_p3 = r_u[1] * r_s[0];
    assign w_p4 = r_u[2] * r_s[1];
    assign w_p5 = r_u[3] * r_s[2];
    assign w_p6 = r_t[5] * r_s[3];

    always_comb begin
        w_mag = w_p6[Q_W+29:30];
        if (w_mag > ONE_Q30) begin
            w_mag = ONE_Q30;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t[0]    <= w_t;
        r_quad[0] <= i_phase[31:30];
        for (int k = 1; k < 6; k++) begin
            r_t[k]    <= r_t[k-1];
            r_quad[k] <= r_quad[k-1];
        end
        r_u[0] <= w_tt[Q_W+29:30];
        for (int k = 1; k < 4; k++) begin
            r_u[k] <= r_u[k-1];
        end
        r_s[0] <= Q_W'(SIN_C7 - w_p2[Q_W+29:30]);
        r_s[1] <= Q_W'(SIN_C5 - w_p3[Q_W+29:30]);
        r_s[2] <= Q_W'(SIN_C3 - w_p4[Q_W+29:30]);
        r_s[3] <= Q_W'(SIN_C1 - w_p5[Q_W+29:30]);
        // lower half turn positive, upper half negative
        if (r_quad[5][1]) begin
            r_sin <= -$signed(PHASE_W'(w_mag));
        end else begin
            r_sin <= $signed(PHASE_W'(w_mag));
        end
    end

    assign o_sin = r_sin;

endmodule

@@ src/crd_back.sv @@
// ============================================================================
// crd_back: direction from yaw and pitch
// Four sine pipelines, the two cos(pitch) products and Q14 rounding.
// ============================================================================
module crd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  crd_pkg::t_angles                    i_angles,
    output logic                                o_valid,
    output logic signed [crd_pkg::DIR_W-1:0]    o_dir_x,
    output logic signed [crd_pkg::DIR_W-1:0]    o_dir_y,
    output logic signed [crd_pkg::DIR_W-1:0]    o_dir_z
);
    import crd_pkg::*;

    localparam logic [PHASE_W-1:0] QUARTER = PHASE_W'(ONE_Q30);

    logic [SIN_LAT+2:0]         r_vld;
    logic [PHASE_W-1:0]         r_ph_yaw;
    logic [PHASE_W-1:0]         r_ph_pitch;
    logic signed [PHASE_W-1:0]  w_sy;
    logic signed [PHASE_W-1:0]  w_cy;
    logic signed [PHASE_W-1:0]  w_sp;
    logic signed [PHASE_W-1:0]  w_cp;
    logic [PHASE_W-1:0]         w_acy;
    logic [PHASE_W-1:0]         w_asy;
    logic [PHASE_W-1:0]         w_acp;
    logic [2*Q_W-1:0]           r_px;
    logic [2*Q_W-1:0]           r_pz;
    logic                       r_nx;
    logic                       r_nz;
    logic signed [PHASE_W-1:0]  r_sp;
    logic [2*Q_W-1:0]           w_rx;
    logic [2*Q_W-1:0]           w_rz;
    logic [Q_W-1:0]             w_ry;
    logic [DIR_W-1:0]           w_mx;
    logic [DIR_W-1:0]           w_mz;
    logic [DIR_W-1:0]           w_my;
    logic signed [DIR_W-1:0]    r_dir_x;
    logic signed [DIR_W-1:0]    r_dir_y;
    logic signed [DIR_W-1:0]    r_dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[SIN_LAT+1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ph_yaw   <= {i_angles.yaw, {(PHASE_W-ANGLE_BITS){1'b0}}};
        r_ph_pitch <= {i_angles.pitch, {(PHASE_W-ANGLE_BITS){1'b0}}};
    end

    crd_sine u_sin_yaw   (.i_clk(i_clk), .i_phase(r_ph_yaw),             .o_sin(w_sy));
    crd_sine u_cos_yaw   (.i_clk(i_clk), .i_phase(r_ph_yaw + QUARTER),   .o_sin(w_cy));
    crd_sine u_sin_pitch (.i_clk(i_clk), .i_phase(r_ph_pitch),           .o_sin(w_sp));
    crd_sine u_cos_pitch (.i_clk(i_clk), .i_phase(r_ph_pitch + QUARTER), .o_sin(w_cp));

    assign w_acy = w_cy[PHASE_W-1] ? PHASE_W'(-w_cy) : PHASE_W'(w_cy);
    assign w_asy = w_sy[PHASE_W-1] ? PHASE_W'(-w_sy) : PHASE_W'(w_sy);
    assign w_acp = w_cp[PHASE_W-1] ? PHASE_W'(-w_cp) : PHASE_W'(w_cp);

    // magnitude products, Q60
    always_ff @(posedge i_clk) begin
        r_px <= w_acp[Q_W-1:0] * w_acy[Q_W-1:0];
        r_pz <= w_acp[Q_W-1:0] * w_asy[Q_W-1:0];
        r_nx <= w_cp[PHASE_W-1] ^ w_cy[PHASE_W-1];
        r_nz <= w_cp[PHASE_W-1] ^ w_sy[PHASE_W-1];
        r_sp <= w_sp;
    end

    // round half up to Q14, clamp at one
    assign w_rx = r_px + (2*Q_W)'(64'd1 << 45);
    assign w_rz = r_pz + (2*Q_W)'(64'd1 << 45);
    assign w_ry = (r_sp[PHASE_W-1] ? Q_W'(-r_sp) : Q_W'(r_sp)) + Q_W'(32768);

    always_comb begin
        w_mx = w_rx[61:46];
        w_mz = w_rz[61:46];
        w_my = DIR_W'(w_ry[30:16]);
        if (w_mx > DIR_ONE) begin
            w_mx = DIR_ONE;
        end
        if (w_mz > DIR_ONE) begin
            w_mz = DIR_ONE;
        end
        if (w_my > DIR_ONE) begin
            w_my = DIR_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dir_x <= r_nx ? -$signed(w_mx) : $signed(w_mx);
        r_dir_z <= r_nz ? -$signed(w_mz) : $signed(w_mz);
        r_dir_y <= r_sp[PHASE_W-1] ? -$signed(w_my) : $signed(w_my);
    end

    assign o_valid = r_vld[SIN_LAT+2];
    assign o_dir_x = r_dir_x;
    assign o_dir_y = r_dir_y;
    assign o_dir_z = r_dir_z;

endmodule

@@ src/camera_ray_direction_unit.sv @@
// ============================================================================
// camera_ray_direction_unit: per-pixel view direction of a yaw/pitch camera
// Pixel coordinate in, unit direction (cos p cos y, sin p, cos p sin y) out.
// ============================================================================
//
//  channel   signals                                 beat taken when
//  -------   -------------------------------------   --------------------------
//  pixel     start, busy, i_pixel_col, i_pixel_row   start && !busy at clk edge
//  ray       o_done, o_dir_x, o_dir_y, o_dir_z       o_done high (one cycle)
//  config    i_cfg_we, i_cfg_index, i_cfg_data       i_cfg_we high at clk edge
//
//  One pixel beat may be taken every cycle. Each ray passes from its pixel
//  beat through the angle front (product stage, one divider stage per
//  numerator bit, final add), the angle queue and the back end (phase
//  stage, seven sine stages, product, rounding). Reset (synchronous, low)
//  empties all pipelines and the queue and loads the register defaults.
//  The ray side cannot stall, so the back end drains the queue every cycle
//  and busy never rises in normal use.
//
module camera_ray_direction_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel beats
    input  logic                                start,
    output logic                                busy,
    input  logic [crd_pkg::COORD_BITS-1:0]      i_pixel_col,
    input  logic [crd_pkg::COORD_BITS-1:0]      i_pixel_row,
    // ray beats
    output logic                                o_done,
    output logic signed [crd_pkg::DIR_W-1:0]    o_dir_x,
    output logic signed [crd_pkg::DIR_W-1:0]    o_dir_y,
    output logic signed [crd_pkg::DIR_W-1:0]    o_dir_z,
    // register writes
    input  logic                                i_cfg_we,
    input  logic [crd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [crd_pkg::REG_W-1:0]           i_cfg_data
);
    import crd_pkg::*;

    // camera registers; the user must write them only while no pixel is in flight (not enforced here)
    logic [REG_W-1:0] r_cam_yaw;
    logic [REG_W-1:0] r_cam_pitch;
    logic [FOV_W-1:0] r_fov_horiz;
    logic [FOV_W-1:0] r_fov_vert;
    logic [DIV_W-1:0] r_image_width;
    logic [DIV_W-1:0] r_image_height;

    logic             w_accept;
    logic             w_yaw_vld;
    logic             w_pitch_vld;
    t_angles          w_front;
    t_angles          w_head;
    logic             w_empty;
    logic             w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_yaw      <= RST_CAM_YAW;
            r_cam_pitch    <= RST_CAM_PITCH;
            r_fov_horiz    <= RST_FOV_HORIZ;
            r_fov_vert     <= RST_FOV_VERT;
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CAM_YAW:      r_cam_yaw      <= i_cfg_data;
                REG_CAM_PITCH:    r_cam_pitch    <= i_cfg_data;
                REG_FOV_HORIZ:    r_fov_horiz    <= i_cfg_data;
                REG_FOV_VERT:     r_fov_vert     <= i_cfg_data;
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[DIV_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[DIV_W-1:0];
                default: ;        // unmapped index: write dropped
            endcase
        end
    end

    assign busy     = w_full;
    assign w_accept = start && !busy;

    // front: column -> yaw, row -> pitch, same fixed latency
    crd_front u_front_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_coord (i_pixel_col),
        .i_base  (r_cam_yaw),
        .i_fov   (r_fov_horiz),
        .i_div   (r_image_width),
        .o_valid (w_yaw_vld),
        .o_angle (w_front.yaw)
    );

    crd_front u_front_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_coord (i_pixel_row),
        .i_base  (r_cam_pitch),
        .i_fov   (r_fov_vert),
        .i_div   (r_image_height),
        .o_valid (w_pitch_vld),
        .o_angle (w_front.pitch)
    );

    // angle queue; the back end pops whenever an entry is waiting
    crd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_yaw_vld && w_pitch_vld),
        .i_data  (w_front),
        .i_pop   (!w_empty),
        .o_data  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    crd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!w_empty),
        .i_angles (w_head),
        .o_valid  (o_done),
        .o_dir_x  (o_dir_x),
        .o_dir_y  (o_dir_y),
        .o_dir_z  (o_dir_z)
    );

endmodule
